FILE: hw/rtl/plca_pkg.sv
`default_nettype none

package plca_pkg;

   localparam int unsigned NumButtons  = 4;
   localparam int unsigned TimerWidth  = 16;
   localparam int unsigned LevelWidth  = 8;
   localparam int unsigned ButtonWidth = 2;

   localparam logic [TimerWidth-1:0] LongDefault = 16'd2000;
   localparam logic [TimerWidth-1:0] TimerMax    = 16'hFFFF;
   localparam logic [LevelWidth:0]   StepSize    = 9'd20;
   localparam logic [LevelWidth:0]   LevelMax    = 9'd255;

   localparam logic [ButtonWidth-1:0] BtnRed   = 2'd0;
   localparam logic [ButtonWidth-1:0] BtnGreen = 2'd1;
   localparam logic [ButtonWidth-1:0] BtnBlue  = 2'd2;
   localparam logic [ButtonWidth-1:0] BtnStep  = 2'd3;

   localparam logic CmdTick  = 1'b0;
   localparam logic CmdEvent = 1'b1;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_TIMING = 2'd1,
      PH_LONG   = 2'd2
   } phase_type;

   function automatic logic [LevelWidth-1:0] bump_level(
      input logic [LevelWidth-1:0] level,
      input logic                  down
   );
      logic [LevelWidth:0] wide;
      wide = {1'b0, level};
      if (down) begin
         if (wide < StepSize) begin
            return LevelMax[LevelWidth-1:0];
         end
         return LevelWidth'(wide - StepSize);
      end
      if ((wide + StepSize) > LevelMax) begin
         return '0;
      end
      return LevelWidth'(wide + StepSize);
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/press_length_color_adjuster.sv
`default_nettype none

// Four-button short/long press classifier that drives an RGB color setting.
// Each request is either a millisecond tick (req_cmd = 0) or a push/release
// of one button (req_cmd = 1). Releasing a button before it has been held for
// csr_wr_data-programmed long_press_ticks ticks (default 2000) gives a short
// press; reaching the threshold gives one long press and a silent release.
// Short presses on buttons 0..2 step red/green/blue by +20 or -20 with
// wraparound, a short press on button 3 flips the step sign, and a long press
// on button 3 clears all levels. Exactly one response follows each request,
// carrying the levels after that request. Requests are accepted while no
// response is pending or it is being taken. State and response are computed
// in one pass and the response is registered; throughput is one request per
// cycle while the response side keeps up. Write the threshold only while idle.
module press_length_color_adjuster
   import plca_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_cmd,
   input  wire logic [ButtonWidth-1:0] req_button,
   input  wire logic                  req_pushed,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_short_valid,
   output logic [ButtonWidth-1:0]     rsp_short_button,
   output logic [NumButtons-1:0]      rsp_long_mask,
   output logic [LevelWidth-1:0]      rsp_red,
   output logic [LevelWidth-1:0]      rsp_green,
   output logic [LevelWidth-1:0]      rsp_blue,
   output logic                       rsp_step_down,
   input  wire logic                  csr_wr_en,
   input  wire logic [TimerWidth-1:0] csr_wr_data
);

   phase_type               phase_ff [NumButtons];
   phase_type               phase_in [NumButtons];
   logic [TimerWidth-1:0]   timer_ff [NumButtons];
   logic [TimerWidth-1:0]   timer_in [NumButtons];
   logic [LevelWidth-1:0]   red_ff, red_in;
   logic [LevelWidth-1:0]   green_ff, green_in;
   logic [LevelWidth-1:0]   blue_ff, blue_in;
   logic                    down_ff, down_in;
   logic [TimerWidth-1:0]   thresh_ff;

   logic                    rsp_valid_ff;
   logic                    short_valid_ff, short_valid_in;
   logic [ButtonWidth-1:0]  short_button_ff, short_button_in;
   logic [NumButtons-1:0]   long_mask_ff, long_mask_in;

   logic                    accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      logic [TimerWidth-1:0] t;
      for (int i = 0; i < NumButtons; i++) begin
         phase_in[i] = phase_ff[i];
         timer_in[i] = timer_ff[i];
      end
      red_in          = red_ff;
      green_in        = green_ff;
      blue_in         = blue_ff;
      down_in         = down_ff;
      short_valid_in  = 1'b0;
      short_button_in = '0;
      long_mask_in    = '0;
      t               = '0;

      if (req_cmd == CmdTick) begin
         for (int i = 0; i < NumButtons; i++) begin
            if (phase_ff[i] == PH_TIMING) begin
               t = (timer_ff[i] == TimerMax) ? timer_ff[i] : timer_ff[i] + 1'b1;
               timer_in[i] = t;
               if (t >= thresh_ff) begin
                  phase_in[i]     = PH_LONG;
                  long_mask_in[i] = 1'b1;
                  if (ButtonWidth'(i) == BtnStep) begin
                     red_in   = '0;
                     green_in = '0;
                     blue_in  = '0;
                  end
               end
            end
         end
      end else if (req_pushed) begin
         if (phase_ff[req_button] != PH_TIMING && phase_ff[req_button] != PH_LONG) begin
            phase_in[req_button] = PH_TIMING;
            timer_in[req_button] = '0;
         end
      end else begin
         case (phase_ff[req_button])
            PH_TIMING: begin
               phase_in[req_button] = PH_IDLE;
               timer_in[req_button] = '0;
               short_valid_in       = 1'b1;
               short_button_in      = req_button;
               case (req_button)
                  BtnStep:  down_in  = !down_ff;
                  BtnBlue:  blue_in  = bump_level(blue_ff, down_ff);
                  BtnGreen: green_in = bump_level(green_ff, down_ff);
                  default:  red_in   = bump_level(red_ff, down_ff);
               endcase
            end
            PH_LONG: begin
               phase_in[req_button] = PH_IDLE;
               timer_in[req_button] = '0;
            end
            default: begin
               phase_in[req_button] = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumButtons; i++) begin
            phase_ff[i] <= PH_IDLE;
            timer_ff[i] <= '0;
         end
         red_ff       <= '0;
         green_ff     <= '0;
         blue_ff      <= '0;
         down_ff      <= 1'b0;
         thresh_ff    <= LongDefault;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            thresh_ff <= csr_wr_data;
         end
         if (accept) begin
            for (int i = 0; i < NumButtons; i++) begin
               phase_ff[i] <= phase_in[i];
               timer_ff[i] <= timer_in[i];
            end
            red_ff   <= red_in;
            green_ff <= green_in;
            blue_ff  <= blue_in;
            down_ff  <= down_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // hold response payload until taken
   always_ff @(posedge clock) begin
      if (accept) begin
         short_valid_ff  <= short_valid_in;
         short_button_ff <= short_button_in;
         long_mask_ff    <= long_mask_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_short_valid  = short_valid_ff;
   assign rsp_short_button = short_button_ff;
   assign rsp_long_mask    = long_mask_ff;
   assign rsp_red          = red_ff;
   assign rsp_green        = green_ff;
   assign rsp_blue         = blue_ff;
   assign rsp_step_down    = down_ff;

   a_short_no_long: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_short_valid |-> rsp_long_mask == '0)
      else $error("short press and long press in one response");

   a_button_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_short_valid |-> rsp_short_button == '0)
      else $error("short button set without short press");

   a_accept_valid: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted request produced no response");

   a_step_flip: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(down_ff))
      else $error("step sign changed without a request");

   a_clear_on_long3: assert property (@(posedge clock) disable iff (reset)
      accept && long_mask_in[BtnStep] |=> red_ff == '0 && green_ff == '0 && blue_ff == '0)
      else $error("long press on step button did not clear levels");

endmodule

`default_nettype wire
